// ===== src/kqss_pkg.sv =====
// Shared constants, codes and controller/datapath interface types for the shared-store queues.
package kqss_pkg;

  localparam int NUM_SLOTS  = 16;
  localparam int NUM_QUEUES = 4;

  localparam int DATA_W   = 32;
  localparam int QNUM_W   = 3;
  localparam int STATUS_W = 2;

  // slot codes carry one extra value for the null link
  localparam int SLOT_W  = $clog2(NUM_SLOTS + 1);
  localparam int SADDR_W = $clog2(NUM_SLOTS);
  localparam int QIDX_W  = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
  localparam int SWEEP_N = (NUM_SLOTS > NUM_QUEUES) ? NUM_SLOTS : NUM_QUEUES;
  localparam int SWEEP_W = $clog2(SWEEP_N);

  localparam logic [SLOT_W-1:0] NULL_LINK = SLOT_W'(NUM_SLOTS);

  localparam logic FUNC_ENQ = 1'b0;
  localparam logic FUNC_DEQ = 1'b1;

  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_OVERFLOW  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_UNDERFLOW = 2'd2;
  localparam logic [STATUS_W-1:0] ST_BAD_QUEUE = 2'd3;

  typedef struct packed {
    logic                accept;
    logic                enq_commit;
    logic                deq_commit;
    logic                null_wr;
    logic                emit;
    logic [STATUS_W-1:0] code;
    logic                sweep;
  } kqss_cmd_t;

  typedef struct packed {
    logic bad_queue;
    logic is_deq;
    logic head_null;
    logic free_null;
    logic sweep_last;
    logic out_free;
  } kqss_stat_t;

endpackage

// ===== src/kqss_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module kqss_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                       clk,
  input  logic                                       we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                           wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                           rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== src/kqss_ctrl.sv =====
// Sequencer for the shared-store queues: reset sweep, lookup, link and write-back steps.
module kqss_ctrl import kqss_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       req_valid,
  output logic       req_stall,
  input  kqss_stat_t stat,
  output kqss_cmd_t  cmd
);

  localparam logic [2:0] S_SWEEP = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_LOOK  = 3'd2;
  localparam logic [2:0] S_LINK  = 3'd3;
  localparam logic [2:0] S_WR2   = 3'd4;

  logic [2:0] state, state_next;

  assign req_stall = (state != S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_SWEEP: begin
        cmd.sweep = 1'b1;
        if (stat.sweep_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (req_valid) begin
          cmd.accept = 1'b1;
          state_next = S_LOOK;
        end
      end
      S_LOOK: begin
        // head/tail read data is ready; error cases finish here
        priority if (stat.bad_queue) begin
          cmd.code = ST_BAD_QUEUE;
          if (stat.out_free) begin
            cmd.emit   = 1'b1;
            state_next = S_IDLE;
          end
        end else if (!stat.is_deq && stat.free_null) begin
          cmd.code = ST_OVERFLOW;
          if (stat.out_free) begin
            cmd.emit   = 1'b1;
            state_next = S_IDLE;
          end
        end else if (stat.is_deq && stat.head_null) begin
          cmd.code = ST_UNDERFLOW;
          if (stat.out_free) begin
            cmd.emit   = 1'b1;
            state_next = S_IDLE;
          end
        end else begin
          state_next = S_LINK;
        end
      end
      S_LINK: begin
        cmd.code = ST_OK;
        if (stat.out_free) begin
          cmd.emit = 1'b1;
          if (stat.is_deq) begin
            cmd.deq_commit = 1'b1;
            state_next     = S_IDLE;
          end else begin
            cmd.enq_commit = 1'b1;
            state_next     = S_WR2;
          end
        end
      end
      S_WR2: begin
        // terminate the new tail's link
        cmd.null_wr = 1'b1;
        state_next  = S_IDLE;
      end
      default: begin
        state_next = S_SWEEP;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_SWEEP;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ===== src/kqss_datapath.sv =====
// Datapath: head, tail, link and value stores, free-list head, item latch and result register.
module kqss_datapath import kqss_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  kqss_cmd_t                cmd,
  output kqss_stat_t               stat,
  input  logic                     func,
  input  logic [QNUM_W-1:0]        queue_number,
  input  logic signed [DATA_W-1:0] data_in,
  output logic                     rsp_valid,
  input  logic                     rsp_stall,
  output logic signed [DATA_W-1:0] data_out,
  output logic [STATUS_W-1:0]      status
);

  logic [SLOT_W-1:0]  free_head;
  logic [SLOT_W-1:0]  slot_reg;
  logic               func_reg;
  logic               bad_reg;
  logic [QIDX_W-1:0]  q_reg;
  logic [DATA_W-1:0]  data_reg;
  logic [SWEEP_W-1:0] sweep_cnt;

  logic [SWEEP_W:0]   sweep_nxt;
  logic               sweep_in_slots;
  logic               sweep_in_queues;
  logic [QIDX_W+QNUM_W-1:0] qnum_m1;
  logic [QIDX_W-1:0]  port_qidx;
  logic               port_bad;

  logic               head_we, tail_we, link_we, value_we;
  logic [QIDX_W-1:0]  head_waddr, tail_waddr, queue_raddr;
  logic [SLOT_W-1:0]  head_wdata, tail_wdata, link_wdata;
  logic [SADDR_W-1:0] link_waddr, link_raddr, value_raddr;
  logic [SLOT_W-1:0]  head_rdata, tail_rdata, link_rdata;
  logic [DATA_W-1:0]  value_rdata;
  logic               head_null, tail_ok;

  assign sweep_nxt       = {1'b0, sweep_cnt} + (SWEEP_W+1)'(1);
  assign sweep_in_slots  = ({1'b0, sweep_cnt} < (SWEEP_W+1)'(NUM_SLOTS));
  assign sweep_in_queues = ({1'b0, sweep_cnt} < (SWEEP_W+1)'(NUM_QUEUES));

  assign qnum_m1   = {{QIDX_W{1'b0}}, queue_number} - (QIDX_W+QNUM_W)'(1);
  assign port_qidx = qnum_m1[QIDX_W-1:0];
  assign port_bad  = (queue_number == '0) ||
                     ({{(32-QNUM_W){1'b0}}, queue_number} > 32'(NUM_QUEUES));

  assign head_null = (head_rdata >= NULL_LINK);
  assign tail_ok   = (tail_rdata <  NULL_LINK);

  // read addresses stay put while a step waits for the result register
  assign queue_raddr = cmd.accept ? port_qidx : q_reg;
  assign link_raddr  = (func_reg == FUNC_DEQ) ? head_rdata[SADDR_W-1:0]
                                              : free_head[SADDR_W-1:0];
  assign value_raddr = head_rdata[SADDR_W-1:0];

  always_comb begin
    head_we    = 1'b0;
    head_waddr = q_reg;
    head_wdata = free_head;
    tail_we    = 1'b0;
    tail_waddr = q_reg;
    tail_wdata = free_head;
    if (cmd.sweep) begin
      head_we    = sweep_in_queues;
      head_waddr = sweep_cnt[QIDX_W-1:0];
      head_wdata = NULL_LINK;
      tail_we    = sweep_in_queues;
      tail_waddr = sweep_cnt[QIDX_W-1:0];
      tail_wdata = NULL_LINK;
    end else if (cmd.enq_commit) begin
      head_we = head_null;
      tail_we = 1'b1;
    end else if (cmd.deq_commit) begin
      head_we    = 1'b1;
      head_wdata = link_rdata;
    end
  end

  always_comb begin
    link_we    = 1'b0;
    link_waddr = slot_reg[SADDR_W-1:0];
    link_wdata = NULL_LINK;
    priority if (cmd.sweep) begin
      // each entry points at the next slot; the last one lands on the null code
      link_we    = sweep_in_slots;
      link_waddr = sweep_cnt[SADDR_W-1:0];
      link_wdata = sweep_nxt[SLOT_W-1:0];
    end else if (cmd.enq_commit) begin
      link_we    = !head_null && tail_ok;
      link_waddr = tail_rdata[SADDR_W-1:0];
      link_wdata = free_head;
    end else if (cmd.deq_commit) begin
      link_we    = 1'b1;
      link_waddr = head_rdata[SADDR_W-1:0];
      link_wdata = free_head;
    end else if (cmd.null_wr) begin
      link_we = 1'b1;
    end else begin
      link_we = 1'b0;
    end
  end

  assign value_we = cmd.enq_commit;

  kqss_ram #(.WIDTH(SLOT_W), .DEPTH(NUM_QUEUES)) u_head (
    .clk(clk), .we(head_we), .waddr(head_waddr), .wdata(head_wdata),
    .raddr(queue_raddr), .rdata(head_rdata)
  );

  kqss_ram #(.WIDTH(SLOT_W), .DEPTH(NUM_QUEUES)) u_tail (
    .clk(clk), .we(tail_we), .waddr(tail_waddr), .wdata(tail_wdata),
    .raddr(queue_raddr), .rdata(tail_rdata)
  );

  kqss_ram #(.WIDTH(SLOT_W), .DEPTH(NUM_SLOTS)) u_link (
    .clk(clk), .we(link_we), .waddr(link_waddr), .wdata(link_wdata),
    .raddr(link_raddr), .rdata(link_rdata)
  );

  kqss_ram #(.WIDTH(DATA_W), .DEPTH(NUM_SLOTS)) u_value (
    .clk(clk), .we(value_we), .waddr(free_head[SADDR_W-1:0]), .wdata(data_reg),
    .raddr(value_raddr), .rdata(value_rdata)
  );

  assign stat.bad_queue  = bad_reg;
  assign stat.is_deq     = (func_reg == FUNC_DEQ);
  assign stat.head_null  = head_null;
  assign stat.free_null  = (free_head >= NULL_LINK);
  assign stat.sweep_last = (sweep_cnt == SWEEP_W'(SWEEP_N - 1));
  assign stat.out_free   = !rsp_valid || !rsp_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      sweep_cnt <= '0;
      free_head <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (cmd.sweep && !stat.sweep_last) begin
        sweep_cnt <= sweep_nxt[SWEEP_W-1:0];
      end
      if (cmd.enq_commit) begin
        free_head <= link_rdata;
      end else if (cmd.deq_commit) begin
        free_head <= head_rdata;
      end
      if (cmd.emit) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      func_reg <= func;
      bad_reg  <= port_bad;
      q_reg    <= port_qidx;
      data_reg <= data_in;
    end
    if (cmd.enq_commit) begin
      slot_reg <= free_head;
    end
    if (cmd.emit) begin
      status <= cmd.code;
      if (cmd.code == ST_UNDERFLOW) begin
        data_out <= '1;
      end else if (cmd.code == ST_OK && func_reg == FUNC_DEQ) begin
        data_out <= value_rdata;
      end else begin
        data_out <= '0;
      end
    end
  end

endmodule

// ===== src/k_queues_shared_store.sv =====
// One transaction at a time: a request is accepted, then looked up; a rejected one has its
// result registered in the lookup step, the others in the link step, each waiting while the
// result register is held, and an enqueue then adds a write-back step that nulls its new tail link.
// Reset: synchronous; afterwards a sweep rebuilds the free list and empties the queues, with
// the request side stalled throughout.
module k_queues_shared_store import kqss_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     req_valid,
  output logic                     req_stall,
  input  logic                     func,
  input  logic [QNUM_W-1:0]        queue_number,
  input  logic signed [DATA_W-1:0] data_in,
  output logic                     rsp_valid,
  input  logic                     rsp_stall,
  output logic signed [DATA_W-1:0] data_out,
  output logic [STATUS_W-1:0]      status
);

  kqss_cmd_t  cmd;
  kqss_stat_t stat;

  kqss_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  kqss_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .func         (func),
    .queue_number (queue_number),
    .data_in      (data_in),
    .rsp_valid    (rsp_valid),
    .rsp_stall    (rsp_stall),
    .data_out     (data_out),
    .status       (status)
  );

endmodule
